// File: hw/rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing calculator package
// Shared widths, timing limits and the divider result type.
// ----------------------------------------------------------------------------
package cbt_pkg;

	// Field widths of the stream and register words.
	localparam int CLK_W  = 32;
	localparam int RATE_W = 24;
	localparam int TQ_W   = 5;
	localparam int SEG_W  = 5;
	localparam int SJW_W  = 3;
	localparam int PSC_W  = 10;
	localparam int OUT_W  = 24;

	// Configuration port: one register, word addressed.
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_KCLK = 1'b0;
	localparam logic [CLK_W-1:0] KCLK_RESET = 32'd80000000;

	// Time quanta limits and sample point rules.
	localparam logic [TQ_W-1:0] TQ_LOW    = 5'd8;
	localparam logic [TQ_W-1:0] TQ_HIGH   = 5'd25;
	localparam logic [TQ_W-1:0] TQ_TARGET = 5'd16;
	localparam logic [TQ_W-1:0] SEG_MIN_BEFORE = 5'd2;
	localparam logic [SJW_W-1:0] SJW_LIMIT = 3'd4;

	// Result of one serial division, with the quotient kept only as far as
	// the quanta range needs it.
	typedef struct packed {
		logic            rem_zero;
		logic            quot_hi;
		logic [TQ_W-1:0] quot;
	} cbt_div_res_t;

	// Distance of a quanta count from the preferred count.
	function automatic logic [TQ_W-1:0] tq_dist(input logic [TQ_W-1:0] v);
		if (v > TQ_TARGET) begin
			return v - TQ_TARGET;
		end
		return TQ_TARGET - v;
	endfunction

endpackage

// File: hw/rtl/cbt_serial_div.sv
// ----------------------------------------------------------------------------
// CAN bit timing serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbt_serial_div
	import cbt_pkg::*;
#(
	parameter int DEN_W = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CLK_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output cbt_div_res_t     res
);

	localparam int CNT_W = $clog2(CLK_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CLK_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [TQ_W-1:0]  quot_q;
	logic             qhi_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] rem_next;

	// One trial subtraction: bring down the next dividend bit.
	always_comb begin
		trial    = {rem_q, num_q[CLK_W-1]};
		diff     = trial - {1'b0, divisor};
		ge       = trial >= {1'b0, divisor};
		rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	// Sequencing of the bit iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and the low quotient bits with a sticky overflow.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			rem_q  <= '0;
			quot_q <= '0;
			qhi_q  <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[CLK_W-2:0], 1'b0};
			rem_q  <= rem_next;
			quot_q <= {quot_q[TQ_W-2:0], ge};
			qhi_q  <= qhi_q | quot_q[TQ_W-1];
		end
	end

	assign done         = done_q;
	assign res.rem_zero = (rem_q == '0);
	assign res.quot_hi  = qhi_q;
	assign res.quot     = quot_q;

endmodule

// File: hw/rtl/can_bit_timing_calculator_core.sv
// ----------------------------------------------------------------------------
// CAN bit timing calculator core
// Finds the nominal bit timing for a requested bit rate and kernel clock.
// ----------------------------------------------------------------------------
// Usage: write the kernel clock in hertz to the register at address 0 over
// the APB port, then send a bit rate word on the s_ stream. One result word
// per request comes out on the m_ stream: status, prescaler, phase segments
// and jump width.
// Search: the core tries every prescaler in turn, one serial division per
// trial, starts each trial as the last one finishes, and registers the result
// word in the output register once the last trial is done. A zero clock or a
// zero rate skips the search and goes straight to the finish state.
// Throughput: one request at a time; s_tready is high only while no search
// is running. A finished result waits in the output register, so the next
// request is taken while the receiver stalls; that search then holds its
// result until the output register is free.
// Reset: the kernel clock register returns to 80 MHz and both streams empty.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator_core
	import cbt_pkg::*;
#(
	parameter int PRESCALER_MAX = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Request stream; tdata: bit_rate[23:0]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [RATE_W-1:0]     s_tdata,
	// Result stream; tdata: status[0], prescaler[10:1], phase_seg1[15:11],
	// phase_seg2[20:16], sync_jump_width[23:21]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int PW    = $clog2(PRESCALER_MAX + 1);
	localparam int DEN_W = RATE_W + PW;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]        state_q;
	logic [CLK_W-1:0]  kclk_q;
	logic [RATE_W-1:0] rate_q;
	logic [DEN_W-1:0]  den_q;
	logic [PW-1:0]     p_q;
	logic [TQ_W-1:0]   best_tq_q;
	logic [PW-1:0]     best_p_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              cfg_wr;
	logic              in_acc;
	logic              args_ok;
	logic              last_p;
	logic              div_start;
	logic              div_done;
	cbt_div_res_t      div_res;
	logic              tq_ok;
	logic              take;
	logic              out_load;

	logic [7:0]        sp_sum;
	logic [TQ_W-1:0]   sp_pos;
	logic              res_status;
	logic [PSC_W-1:0]  res_psc;
	logic [SEG_W-1:0]  res_seg1;
	logic [SEG_W-1:0]  res_seg2;
	logic [SJW_W-1:0]  res_sjw;

	// Configuration register access.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KCLK);
	assign prdata = (paddr[2] == REG_KCLK) ? kclk_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kclk_q <= KCLK_RESET;
		end else if (cfg_wr) begin
			kclk_q <= pwdata;
		end
	end

	// Handshake and search control.
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign args_ok   = (kclk_q != '0) && (s_tdata != '0);
	assign last_p    = (p_q == PW'(PRESCALER_MAX));
	assign div_start = (in_acc && args_ok) ||
	                   (state_q == ST_RUN && div_done && !last_p);
	assign out_load  = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	cbt_serial_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(kclk_q),
		.divisor (den_q),
		.done    (div_done),
		.res     (div_res)
	);

	// A trial counts when it divides exactly into an allowed quanta count;
	// it wins when closer to the target, or as close and longer.
	always_comb begin
		tq_ok = div_res.rem_zero && !div_res.quot_hi &&
		        (div_res.quot >= TQ_LOW) && (div_res.quot <= TQ_HIGH);
		take  = tq_ok && ((best_tq_q == '0) ||
		        (tq_dist(div_res.quot) < tq_dist(best_tq_q)) ||
		        ((tq_dist(div_res.quot) == tq_dist(best_tq_q)) &&
		         (div_res.quot > best_tq_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= args_ok ? ST_RUN : ST_FINISH;
					end
				end
				ST_RUN: begin
					if (div_done && last_p) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search datapath: the divisor steps by the rate for each prescaler.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rate_q    <= s_tdata;
			den_q     <= DEN_W'(s_tdata);
			p_q       <= PW'(1);
			best_tq_q <= '0;
			best_p_q  <= '0;
		end else if (state_q == ST_RUN && div_done) begin
			if (take) begin
				best_tq_q <= div_res.quot;
				best_p_q  <= p_q;
			end
			if (!last_p) begin
				p_q   <= p_q + PW'(1);
				den_q <= den_q + DEN_W'(rate_q);
			end
		end
	end

	// Sample point at seven eighths of the bit, rounded, then clamped.
	always_comb begin
		sp_sum = {best_tq_q, 3'b000} - {3'b000, best_tq_q} + 8'd4;
		sp_pos = sp_sum[7:3];
		if (sp_pos < SEG_MIN_BEFORE) begin
			sp_pos = SEG_MIN_BEFORE;
		end
		if (sp_pos > best_tq_q - TQ_W'(1)) begin
			sp_pos = best_tq_q - TQ_W'(1);
		end
		res_status = (best_tq_q == '0);
		if (res_status) begin
			res_psc  = '0;
			res_seg1 = '0;
			res_seg2 = '0;
			res_sjw  = '0;
		end else begin
			res_psc  = PSC_W'(best_p_q);
			res_seg1 = sp_pos - TQ_W'(1);
			res_seg2 = best_tq_q - sp_pos;
			res_sjw  = (res_seg2 < SEG_W'(SJW_LIMIT)) ? res_seg2[SJW_W-1:0] : SJW_LIMIT;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {res_sjw, res_seg2, res_seg1, res_psc, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: hw/rtl/cbt_checker.sv
// ----------------------------------------------------------------------------
// CAN bit timing calculator checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module cbt_checker
	import cbt_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_W-1:0]      m_tdata
);

	logic [SEG_W-1:0] seg1;
	logic [SEG_W-1:0] seg2;
	logic [SJW_W-1:0] sjw;
	logic [TQ_W:0]    tq_sum;

	assign seg1   = m_tdata[15:11];
	assign seg2   = m_tdata[20:16];
	assign sjw    = m_tdata[23:21];
	assign tq_sum = {1'b0, seg1} + {1'b0, seg2} + 6'd1;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// An invalid status carries zeroed fields.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
		else $error("invalid result with nonzero fields");

	// A valid timing has a legal quanta count, both segments and the jump width.
	a_timing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> seg1 != '0 && seg2 != '0 &&
		tq_sum >= 6'd8 && tq_sum <= 6'd25 &&
		((seg2 < 5'd4) ? (sjw == seg2[2:0]) : (sjw == 3'd4)))
		else $error("inconsistent bit timing");

	// One request at a time: a search never overlaps the next request.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while a search was running");

endmodule

bind can_bit_timing_calculator_core cbt_checker u_cbt_checker (.*);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// CAN bit timing calculator testbench
// Drives bit rate requests into the core under several kernel clock settings,
// predicts each timing result with an independent search over all prescalers,
// and compares every result word field by field, in order, against the
// predictions. Both stream sides idle at random in three pressure modes.
// ----------------------------------------------------------------------------
module tb_top
	import cbt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Search limits of the predictor, matching the core's default build.
	localparam int unsigned PSC_LIMIT       = 512;
	localparam int unsigned SAMPLE_PERMILLE = 875;
	localparam int unsigned SAMPLE_ROUND    = 500;
	localparam int unsigned SAMPLE_SCALE    = 1000;
	localparam int unsigned UNUSED_REG_IDX  = 1;
	localparam int unsigned RATE_MAX        = 24'hFFFFFF;
	localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;
	localparam int unsigned DRAIN_CYCLES    = 100;

	// One result word, highest field first.
	typedef struct packed {
		logic [SJW_W-1:0] sjw;
		logic [SEG_W-1:0] seg2;
		logic [SEG_W-1:0] seg1;
		logic [PSC_W-1:0] psc;
		logic             status;
	} timing_t;

	// Predicts timing results and checks the words that come out.
	class bit_timing_board;
		logic [CLK_W-1:0] kclk_hz;
		timing_t          timing_q[$];
		int unsigned      error_count;

		function new();
			kclk_hz     = KCLK_RESET;
			error_count = 0;
		endfunction

		function void set_kclk(logic [CLK_W-1:0] value);
			kclk_hz = value;
		endfunction

		function int unsigned pending();
			return timing_q.size();
		endfunction

		task report(string msg);
			error_count++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function int unsigned quanta_gap(int unsigned v);
			return (v > TQ_TARGET) ? v - TQ_TARGET : TQ_TARGET - v;
		endfunction

		// Exhaustive prescaler search, then sample point placement.
		function timing_t predict(logic [RATE_W-1:0] rate);
			longint unsigned clk64;
			longint unsigned den;
			longint unsigned quot;
			int unsigned best_p;
			int unsigned best_tq;
			int unsigned tq;
			int unsigned before_sp;
			int unsigned seg1;
			int unsigned seg2;
			timing_t res;
			res = '0;
			res.status = 1'b1;
			clk64 = kclk_hz;
			best_p = 0;
			best_tq = 0;
			if (clk64 == 0 || rate == 0) begin
				return res;
			end
			for (int unsigned p = 1; p <= PSC_LIMIT; p++) begin
				den = longint'(rate) * p;
				if (clk64 % den == 0) begin
					quot = clk64 / den;
					if (quot >= TQ_LOW && quot <= TQ_HIGH) begin
						tq = int'(quot);
						if (best_tq == 0 || quanta_gap(tq) < quanta_gap(best_tq) ||
						    (quanta_gap(tq) == quanta_gap(best_tq) && tq > best_tq)) begin
							best_tq = tq;
							best_p = p;
						end
					end
				end
			end
			if (best_tq == 0) begin
				return res;
			end
			before_sp = (best_tq * SAMPLE_PERMILLE + SAMPLE_ROUND) / SAMPLE_SCALE;
			if (before_sp < SEG_MIN_BEFORE) begin
				before_sp = SEG_MIN_BEFORE;
			end
			if (before_sp > best_tq - 1) begin
				before_sp = best_tq - 1;
			end
			seg1 = before_sp - 1;
			seg2 = best_tq - 1 - seg1;
			res.status = 1'b0;
			res.psc = best_p[PSC_W-1:0];
			res.seg1 = seg1[SEG_W-1:0];
			res.seg2 = seg2[SEG_W-1:0];
			res.sjw = (seg2 < SJW_LIMIT) ? seg2[SJW_W-1:0] : SJW_LIMIT;
			return res;
		endfunction

		function void note_request(logic [RATE_W-1:0] rate);
			timing_q.push_back(predict(rate));
		endfunction

		task check_result(logic [OUT_W-1:0] word);
			timing_t got;
			timing_t want;
			got = timing_t'(word);
			if (timing_q.size() == 0) begin
				report($sformatf("result word %h with no request waiting", word));
			end else begin
				want = timing_q.pop_front();
				if (got.status !== want.status)
					report($sformatf("status got %0d expected %0d", got.status, want.status));
				if (got.psc !== want.psc)
					report($sformatf("prescaler got %0d expected %0d", got.psc, want.psc));
				if (got.seg1 !== want.seg1)
					report($sformatf("phase_seg1 got %0d expected %0d", got.seg1, want.seg1));
				if (got.seg2 !== want.seg2)
					report($sformatf("phase_seg2 got %0d expected %0d", got.seg2, want.seg2));
				if (got.sjw !== want.sjw)
					report($sformatf("sync_jump_width got %0d expected %0d", got.sjw, want.sjw));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr    = '0;
	logic [31:0]           pwdata   = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [RATE_W-1:0]     s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;

	bit_timing_board sb;
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_idle_pct = 0;
	longint unsigned cycles = 0;

	can_bit_timing_calculator_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // bit_rate[23:0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // status, prescaler, phase_seg1, phase_seg2, sync_jump_width
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("can_bit_timing_calculator_core verification failed");
			$finish;
		end
	end

	// Result side: random stalls, and a check of every accepted word.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Sends one request word, with random idle cycles ahead of it.
	task send_rate(logic [RATE_W-1:0] rate);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= rate;
		do @(posedge clk); while (!s_tready);
		sb.note_request(rate);
	endtask

	// Lowers the request stream and waits until every result has arrived.
	task wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle.
	task cfg_write(int unsigned index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (index == REG_KCLK) begin
			sb.set_kclk(value);
		end
	endtask

	function void set_pressure(int mode);
		case (mode)
			0: begin
				send_idle_pct = 9;
				recv_idle_pct = 71;
			end
			1: begin
				send_idle_pct = 71;
				recv_idle_pct = 9;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endfunction

	// Kernel clocks with many small divisors, plus the extremes and noise.
	function logic [CLK_W-1:0] pick_clock();
		logic [CLK_W-1:0] common_clocks [12];
		int unsigned pick;
		common_clocks = '{32'd80000000, 32'd40000000, 32'd48000000, 32'd24000000,
			32'd16000000, 32'd20000000, 32'd64000000, 32'd60000000,
			32'd36000000, 32'd100000000, 32'd120000000, 32'd8000000};
		pick = $urandom_range(0, 11);
		if (pick == 0)
			return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFFFFFF;
		if (pick == 1)
			return $urandom;
		return common_clocks[$urandom_range(0, 11)];
	endfunction

	// Mostly rates that divide the clock into a legal quanta count.
	function logic [RATE_W-1:0] pick_rate();
		longint unsigned clk64;
		longint unsigned prod;
		int unsigned kind;
		int unsigned p;
		int unsigned tq;
		clk64 = sb.kclk_hz;
		kind = $urandom_range(0, 99);
		if (kind < 75 && clk64 != 0) begin
			for (int tries = 0; tries < 40; tries++) begin
				p = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PSC_LIMIT)
				                                : $urandom_range(1, 16);
				tq = $urandom_range(TQ_LOW, TQ_HIGH);
				prod = longint'(p) * tq;
				if (clk64 % prod == 0 && clk64 / prod <= RATE_MAX) begin
					return RATE_W'(clk64 / prod);
				end
			end
		end
		if (kind < 90)
			return RATE_W'($urandom);
		if (kind < 96)
			return RATE_W'($urandom_range(1, 1000000));
		return '0;
	endfunction

	// Stimulus sequence.
	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset clock of 80 MHz.
		set_pressure(0);
		send_rate(24'd500000);
		send_rate(24'd1000000);
		send_rate(24'd250000);
		send_rate(24'd125000);
		send_rate(24'd5000000);   // one prescaler, preferred count
		send_rate(24'd10000000);  // shortest count
		send_rate(24'd3200000);   // longest count
		send_rate(24'd156250);
		send_rate(24'd20000);
		send_rate(24'd0);         // zero rate
		send_rate(24'd1);         // quanta count far too large everywhere
		send_rate(24'hFFFFFF);    // no exact division at all
		send_rate(24'd33333);

		// Equal distance from the preferred count: the longer count wins.
		wait_idle();
		cfg_write(REG_KCLK, 32'd25500000);
		send_rate(24'd100000);
		send_rate(24'd1500000);

		// Zero kernel clock.
		wait_idle();
		cfg_write(REG_KCLK, 32'd0);
		send_rate(24'd500000);
		send_rate(24'd0);

		// Largest kernel clock; the rate below needs prescaler 257.
		wait_idle();
		cfg_write(REG_KCLK, 32'hFFFFFFFF);
		send_rate(24'd1114129);
		send_rate(24'hFFFFFF);
		send_rate(24'd1);

		// A write past the last register must leave the clock alone.
		wait_idle();
		cfg_write(UNUSED_REG_IDX, 32'h12345678);
		send_rate(24'd1114129);

		// Random phases, a new kernel clock in each.
		for (int mode = 0; mode < 3; mode++) begin
			set_pressure(mode);
			for (int phase = 0; phase < 4; phase++) begin
				wait_idle();
				cfg_write(REG_KCLK, pick_clock());
				repeat (8) send_rate(pick_rate());
			end
		end

		// Drain, then let a stray word show up if there is one.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("can_bit_timing_calculator_core verification clean");
		end else begin
			$display("can_bit_timing_calculator_core verification failed");
		end
		$finish;
	end

endmodule
